@@ rtl/viterbi_melody_follower_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the melody follower
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef VITERBI_MELODY_FOLLOWER_CORE_MACROS_SVH
`define VITERBI_MELODY_FOLLOWER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define VMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/vmf_pkg.sv @@
// ----------------------------------------------------------------------------
// Melody follower package
// Widths, constants, cell bundle types and saturating score arithmetic.
// ----------------------------------------------------------------------------
package vmf_pkg;

   localparam int DEF_MAX_NOTES       = 64;
   localparam int DEF_BLOCKS_PER_BEAT = 43;

   localparam int SCORE_W = 32;
   localparam int LN_W    = 13;
   localparam int OBS_W   = 24;
   localparam int PITCH_W = 7;
   localparam int LEN_W   = 16;
   localparam int POS_W   = 16;
   localparam int MEAS_W  = 11;
   localparam int PROB_W  = 17;
   localparam int CVAL_W  = 15;

   localparam logic signed [SCORE_W-1:0] SEED_LN2_Q8 = 32'sd177;
   localparam logic [CVAL_W-1:0] C_BASE_Q16      = 15'd3277;
   localparam logic [CVAL_W-1:0] C_TOP_Q16       = 15'd19661;
   localparam logic [15:0]       NEXT_SHARE_Q16  = 16'd63984;
   localparam logic [15:0]       OTHER_SHARE_Q16 = 16'd1553;
   localparam logic [11:0]       LN2_Q12         = 12'd2839;

   localparam logic [1:0] OPC_LOAD     = 2'd0;
   localparam logic [1:0] OPC_VOICED   = 2'd1;
   localparam logic [1:0] OPC_UNVOICED = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_ROTATE,
      CELL_OBS,
      CELL_CAND,
      CELL_COMMIT,
      CELL_NORM
   } cell_op_type;

   // Per-state data that travels around the ring of cells.
   typedef struct packed {
      logic [LEN_W-1:0]          len;
      logic [POS_W-1:0]          pos;
      logic signed [SCORE_W-1:0] path;
      logic signed [LN_W-1:0]    lns;
      logic signed [LN_W-1:0]    lnn;
      logic signed [LN_W-1:0]    lno;
      logic signed [SCORE_W-1:0] nxt;
   } bundle_type;

   typedef struct packed {
      cell_op_type               op;
      logic [5:0]                load_idx;
      logic [PITCH_W-1:0]        load_pitch;
      logic [LEN_W-1:0]          load_len;
      logic [POS_W-1:0]          load_pos;
      logic [MEAS_W-1:0]         measured;
      logic                      use_cand;
      logic                      first;
      logic signed [SCORE_W-1:0] win;
   } cell_ctl_type;

   function automatic logic signed [SCORE_W-1:0] sat_wide(input logic signed [SCORE_W:0] s);
      logic signed [SCORE_W-1:0] r;
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         r = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
      end else begin
         r = s[SCORE_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat_add(input logic signed [SCORE_W-1:0] a,
                                                         input logic signed [SCORE_W-1:0] b);
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
      return sat_wide(s);
   endfunction

   function automatic logic signed [SCORE_W-1:0] sat_sub(input logic signed [SCORE_W-1:0] a,
                                                         input logic signed [SCORE_W-1:0] b);
      logic signed [SCORE_W:0] s;
      s = {a[SCORE_W-1], a} - {b[SCORE_W-1], b};
      return sat_wide(s);
   endfunction

endpackage

@@ rtl/viterbi_melody_follower_core.sv @@
// ----------------------------------------------------------------------------
// Viterbi melody follower core
// One hidden-Markov Viterbi step per voiced tick, with states loaded, over a ring of note cells.
// ----------------------------------------------------------------------------
// The block keeps up to MAX_NOTES note states, one in each cell of a ring.
// A load word writes one state and re-seeds all path scores; an unvoiced tick
// clears the run length; both, an unknown opcode and a voiced tick with no
// state loaded answer at once with an invalid result word. A voiced tick with
// states loaded runs a full trellis step and answers with the winning state
// and its melody position plus one. The one shared log unit builds the
// transition table: for each loaded state, three log evaluations plus setup,
// a reciprocal-multiply division when its note ends within a beat, and the
// insertion; each unused cell is just rotated past. Then come two full trips
// around the ring (candidate scoring and the winner scan) and the commit,
// normalise and done bookkeeping. One item is in work at a time. The result
// sits in an output register, and a new word is taken while it waits only if
// the output is being drained in the same cycle.
// ----------------------------------------------------------------------------
module viterbi_melody_follower_core import vmf_pkg::*; #(
   parameter int MAX_NOTES       = DEF_MAX_NOTES,
   parameter int BLOCKS_PER_BEAT = DEF_BLOCKS_PER_BEAT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_opcode,
   input  logic [5:0]          req_entry_index,
   input  logic [PITCH_W-1:0]  req_note_pitch,
   input  logic [LEN_W-1:0]    req_expected_blocks,
   input  logic [POS_W-1:0]    req_melody_position,
   input  logic [MEAS_W-1:0]   req_measured_pitch,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_result_valid,
   output logic [16:0]         rsp_position_plus_one,
   output logic [5:0]          rsp_winner_state
);

   localparam int IDX_W = $clog2(MAX_NOTES);

   // Reciprocal of the beat length in Q34, rounded up. The remaining blocks
   // are below the beat length, so the product shifted down by 20 gives the
   // exact floor of 16384*rem/BLOCKS_PER_BEAT.
   localparam longint unsigned RECIP_WIDE =
      ((64'd1 << 34) + 64'(BLOCKS_PER_BEAT) - 64'd1) / 64'(BLOCKS_PER_BEAT);
   localparam logic [34:0] RECIP_Q34 = 35'(RECIP_WIDE);

   typedef enum logic [3:0] {
      S_IDLE, S_OBS, S_STEP, S_DIV, S_PROB, S_OTHER, S_LN_STAY, S_LN_NEXT,
      S_LN_OTHER, S_INSERT, S_CAND, S_COMMIT, S_SCAN, S_NORM, S_DONE
   } state_type;

   state_type                  state_ff;
   logic [IDX_W-1:0]           k_ff;
   logic [6:0]                 count_ff;
   logic [LEN_W-1:0]           run_ff;
   logic [MEAS_W-1:0]          meas_ff;
   logic [CVAL_W-1:0]          quot_ff;
   logic [CVAL_W-1:0]          c_ff;
   logic [15:0]                next_p_ff;
   logic [15:0]                other_p_ff;
   logic signed [LN_W-1:0]     lns_ff;
   logic signed [LN_W-1:0]     lnn_ff;
   logic signed [SCORE_W-1:0]  win_ff;
   logic [POS_W-1:0]           win_pos_ff;
   logic [IDX_W-1:0]           win_idx_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_result_valid_ff;
   logic [16:0]                rsp_pos_ff;
   logic [5:0]                 rsp_win_ff;

   cell_ctl_type               ctl;
   bundle_type                 tail;
   bundle_type                 cell_out [MAX_NOTES];
   bundle_type                 head;

   logic                       accept;
   logic                       out_free;
   logic                       rsp_load;
   logic                       k_last;
   logic                       k_active;
   logic [IDX_W-1:0]           k_succ;
   logic [LEN_W-1:0]           rem;
   logic [44:0]                div_prod;
   logic                       ln_start;
   logic [PROB_W-1:0]          ln_x;
   logic                       ln_done;
   logic signed [LN_W-1:0]     ln_res;
   logic [31:0]                next_mul;
   logic [31:0]                other_mul;

   assign head      = cell_out[0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign k_last    = (k_ff == IDX_W'(MAX_NOTES - 1));
   assign k_active  = (int'(k_ff) < int'(count_ff));
   assign k_succ    = k_last ? '0 : k_ff + 1'b1;

   // The output register takes a word at once for every item except a voiced
   // tick with states loaded, whose word is written when the step is done.
   assign rsp_load  = (accept && !(req_opcode == OPC_VOICED && count_ff != '0)) ||
                      (state_ff == S_DONE && out_free);

   // Remaining blocks of the head state's note, floored at zero.
   assign rem       = (head.len > run_ff) ? head.len - run_ff : '0;
   assign div_prod  = {35'd0, rem[9:0]} * {10'd0, RECIP_Q34};
   assign next_mul  = {17'd0, c_ff} * {16'd0, NEXT_SHARE_Q16} + 32'd32768;
   assign other_mul = {17'd0, c_ff} * {16'd0, OTHER_SHARE_Q16} + 32'd32768;

   // The log unit is started three times per state: stay, next, other.
   always_comb begin
      ln_start = 1'b0;
      ln_x     = PROB_W'(17'd65536 - {2'b00, c_ff});
      unique case (state_ff)
         S_OTHER:   ln_start = 1'b1;
         S_LN_STAY: begin
            ln_start = ln_done;
            ln_x     = {1'b0, next_p_ff};
         end
         S_LN_NEXT: begin
            ln_start = ln_done;
            ln_x     = {1'b0, other_p_ff};
         end
         default: ;
      endcase
   end

   vmf_ln u_ln (
      .clock  (clock),
      .reset  (reset),
      .start  (ln_start),
      .x      (ln_x),
      .done   (ln_done),
      .result (ln_res)
   );

   // Cell commands. The head of the ring is broadcast, and the tail input is
   // the head itself, so a full trip around the ring puts every state home.
   always_comb begin
      ctl            = '0;
      ctl.op         = CELL_HOLD;
      ctl.load_idx   = req_entry_index;
      ctl.load_pitch = req_note_pitch;
      ctl.load_len   = req_expected_blocks;
      ctl.load_pos   = req_melody_position;
      ctl.measured   = meas_ff;
      ctl.use_cand   = k_active;
      ctl.first      = (k_ff == '0);
      ctl.win        = win_ff;
      tail           = head;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == OPC_LOAD && int'(req_entry_index) < MAX_NOTES) begin
               ctl.op = CELL_LOAD;
            end
         end
         S_OBS:  ctl.op = CELL_OBS;
         S_STEP: begin
            if (!k_active) ctl.op = CELL_ROTATE;
         end
         S_INSERT: begin
            ctl.op   = CELL_ROTATE;
            tail.lns = lns_ff;
            tail.lnn = lnn_ff;
            tail.lno = ln_res;
         end
         S_CAND:   ctl.op = CELL_CAND;
         S_COMMIT: ctl.op = CELL_COMMIT;
         S_SCAN:   ctl.op = CELL_ROTATE;
         S_NORM:   ctl.op = CELL_NORM;
         default: ;
      endcase
   end

   for (genvar i = 0; i < MAX_NOTES; i++) begin : g_cell
      vmf_cell #(
         .CELL_INDEX (i),
         .IDX_W      (IDX_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .o_idx     (k_ff),
         .bcast     (head),
         .chain_in  ((i == MAX_NOTES - 1) ? tail : cell_out[(i + 1) % MAX_NOTES]),
         .chain_out (cell_out[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  rsp_result_valid_ff <= 1'b0;
                  rsp_pos_ff          <= '0;
                  rsp_win_ff          <= '0;
                  case (req_opcode)
                     OPC_LOAD: begin
                        if (int'(req_entry_index) < MAX_NOTES) begin
                           count_ff <= {1'b0, req_entry_index} + 7'd1;
                        end
                     end
                     OPC_UNVOICED: run_ff <= '0;
                     OPC_VOICED: begin
                        if (run_ff != '1) run_ff <= run_ff + 16'd1;
                        meas_ff <= req_measured_pitch;
                        // With states loaded, the real answer comes later.
                        if (count_ff != '0) state_ff <= S_OBS;
                     end
                     default: ;
                  endcase
               end
            end
            S_OBS: begin
               k_ff     <= '0;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               if (k_active) begin
                  if (int'(rem) < BLOCKS_PER_BEAT) begin
                     state_ff <= S_DIV;
                  end else begin
                     c_ff     <= C_BASE_Q16;
                     state_ff <= S_PROB;
                  end
               end else begin
                  k_ff <= k_succ;
                  if (k_last) state_ff <= S_CAND;
               end
            end
            S_DIV: begin
               // Quotient by the beat length through the reciprocal multiply.
               quot_ff  <= div_prod[20 +: CVAL_W];
               state_ff <= S_PROB;
            end
            S_PROB: begin
               if (int'(rem) < BLOCKS_PER_BEAT) begin
                  c_ff <= C_TOP_Q16 - quot_ff;
               end
               state_ff <= S_OTHER;
            end
            S_OTHER: begin
               next_p_ff  <= next_mul[31:16];
               other_p_ff <= other_mul[31:16];
               state_ff   <= S_LN_STAY;
            end
            S_LN_STAY: begin
               if (ln_done) begin
                  lns_ff   <= ln_res;
                  state_ff <= S_LN_NEXT;
               end
            end
            S_LN_NEXT: begin
               if (ln_done) begin
                  lnn_ff   <= ln_res;
                  state_ff <= S_LN_OTHER;
               end
            end
            S_LN_OTHER: begin
               if (ln_done) state_ff <= S_INSERT;
            end
            S_INSERT: begin
               k_ff     <= k_succ;
               state_ff <= k_last ? S_CAND : S_STEP;
            end
            S_CAND: begin
               k_ff <= k_succ;
               if (k_last) state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               k_ff     <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // Strictly greater keeps the lowest state on a tie.
               if (k_active && (k_ff == '0 || head.nxt > win_ff)) begin
                  win_ff     <= head.nxt;
                  win_pos_ff <= head.pos;
                  win_idx_ff <= k_ff;
               end
               k_ff <= k_succ;
               if (k_last) state_ff <= S_NORM;
            end
            S_NORM: state_ff <= S_DONE;
            S_DONE: begin
               if (out_free) begin
                  rsp_result_valid_ff <= 1'b1;
                  rsp_pos_ff          <= {1'b0, win_pos_ff} + 17'd1;
                  rsp_win_ff          <= 6'(win_idx_ff);
                  state_ff            <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_valid      = rsp_result_valid_ff;
   assign rsp_position_plus_one = rsp_pos_ff;
   assign rsp_winner_state      = rsp_win_ff;

endmodule

@@ rtl/vmf_ln.sv @@
// ----------------------------------------------------------------------------
// Natural log unit
// Iterative log2 by repeated squaring, scaled by ln2, result in Q8.
// ----------------------------------------------------------------------------
module vmf_ln import vmf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [PROB_W-1:0]        x,
   output logic                     done,
   output logic signed [LN_W-1:0]   result
);

   typedef enum logic [1:0] {LN_IDLE, LN_SQUARE, LN_SCALE, LN_ROUND} ln_state_type;

   ln_state_type             state_ff;
   logic [30:0]              y_ff;
   logic signed [17:0]       lg_ff;
   logic [3:0]               cnt_ff;
   logic signed [30:0]       v_ff;
   logic signed [LN_W-1:0]   result_ff;
   logic                     done_ff;

   logic [4:0]               msb;
   logic [30:0]              y_init;
   logic signed [5:0]        exp_int;
   logic [61:0]              prod;
   logic [31:0]              sq_hi;
   logic [30:0]              v_abs;
   logic [14:0]              rnd;

   always_comb begin
      msb = '0;
      for (int i = 0; i < PROB_W; i++) begin
         if (x[i]) msb = 5'(i);
      end
   end

   assign y_init  = 31'({15'd0, x} << (5'd30 - msb));
   assign exp_int = $signed({1'b0, msb}) - 6'sd16;
   assign prod    = {31'd0, y_ff} * {31'd0, y_ff};
   assign sq_hi   = prod[61:30];
   assign v_abs   = v_ff[30] ? 31'(-v_ff) : 31'(v_ff);
   assign rnd     = 15'((v_abs + 31'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LN_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            LN_IDLE: begin
               if (start) begin
                  y_ff     <= y_init;
                  lg_ff    <= {exp_int, 12'd0};
                  cnt_ff   <= '0;
                  state_ff <= LN_SQUARE;
               end
            end
            LN_SQUARE: begin
               if (sq_hi[31]) begin
                  y_ff  <= sq_hi[31:1];
                  lg_ff <= lg_ff + $signed({6'd0, 12'(12'd2048 >> cnt_ff)});
               end else begin
                  y_ff <= sq_hi[30:0];
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd11) state_ff <= LN_SCALE;
            end
            LN_SCALE: begin
               v_ff     <= 31'(lg_ff * $signed({1'b0, LN2_Q12}));
               state_ff <= LN_ROUND;
            end
            LN_ROUND: begin
               result_ff <= v_ff[30] ? -$signed(LN_W'(rnd)) : $signed(LN_W'(rnd));
               done_ff   <= 1'b1;
               state_ff  <= LN_IDLE;
            end
            default: state_ff <= LN_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ rtl/vmf_cell.sv @@
// ----------------------------------------------------------------------------
// Trellis cell
// Holds one note state, scores candidates broadcast from the head of the ring.
// ----------------------------------------------------------------------------
module vmf_cell import vmf_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int IDX_W      = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  logic [IDX_W-1:0]   o_idx,
   input  bundle_type         bcast,
   input  bundle_type         chain_in,
   output bundle_type         chain_out
);

   localparam logic signed [SCORE_W-1:0] SEED = (CELL_INDEX == 0) ? SEED_LN2_Q8 : '0;

   bundle_type                bundle_ff;
   logic [PITCH_W-1:0]        pitch_ff;
   logic signed [OBS_W-1:0]   obs_ff;
   logic signed [SCORE_W-1:0] best_ff;

   logic signed [12:0]        err;
   logic signed [25:0]        err_sq;
   logic signed [LN_W-1:0]    trans;
   logic signed [SCORE_W-1:0] part;
   logic signed [SCORE_W-1:0] cand;
   logic                      hit;

   assign err    = $signed({2'b00, pitch_ff, 4'b0000}) - $signed({2'b00, ctl.measured});
   assign err_sq = err * err;
   assign hit    = (int'(ctl.load_idx) == CELL_INDEX);

   always_comb begin
      if (int'(o_idx) == CELL_INDEX) begin
         trans = bcast.lns;
      end else if (int'(o_idx) + 1 == CELL_INDEX) begin
         trans = bcast.lnn;
      end else begin
         trans = bcast.lno;
      end
      part = sat_add(bcast.path, SCORE_W'(trans));
      cand = sat_add(part, SCORE_W'(obs_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bundle_ff.path <= SEED;
      end else begin
         unique case (ctl.op)
            CELL_HOLD: ;
            CELL_LOAD: begin
               bundle_ff.path <= SEED;
               if (hit) begin
                  pitch_ff      <= ctl.load_pitch;
                  bundle_ff.len <= ctl.load_len;
                  bundle_ff.pos <= ctl.load_pos;
               end
            end
            CELL_ROTATE: bundle_ff <= chain_in;
            CELL_OBS:    obs_ff <= OBS_W'(-err_sq);
            CELL_CAND: begin
               bundle_ff <= chain_in;
               if (ctl.use_cand && (ctl.first || cand > best_ff)) best_ff <= cand;
            end
            CELL_COMMIT: bundle_ff.nxt <= best_ff;
            CELL_NORM:   bundle_ff.path <= sat_sub(bundle_ff.nxt, ctl.win);
            default: ;
         endcase
      end
   end

   assign chain_out = bundle_ff;

endmodule

@@ rtl/vmf_checker.sv @@
// ----------------------------------------------------------------------------
// Melody follower port checker
// Watches the top-level ports and flags handshake and result-word slips.
// ----------------------------------------------------------------------------
`include "viterbi_melody_follower_core_macros.svh"

module vmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_valid,
   input logic [16:0] rsp_position_plus_one,
   input logic [5:0]  rsp_winner_state
);

   // A stalled result word keeps its valid flag and position.
   `VMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position_plus_one) && $stable(rsp_result_valid), "result word changed while stalled")

   // A request is only taken when the output register can take its answer.
   `VMF_ASSERT_NOW(a_req_room, clock, reset, req_valid && req_ready, !rsp_valid || rsp_ready, "request accepted with output full")

   // Invalid result words carry zero fields.
   `VMF_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_valid && !rsp_result_valid, rsp_position_plus_one == 17'd0 && rsp_winner_state == 6'd0, "invalid result word has nonzero fields")

   // A valid position is always one past a melody index.
   `VMF_ASSERT_NOW(a_valid_pos, clock, reset, rsp_valid && rsp_result_valid, rsp_position_plus_one != 17'd0, "valid result word reports position zero")

endmodule

bind viterbi_melody_follower_core vmf_checker u_vmf_checker (.*);

@@ test/viterbi_melody_follower_core_tb.sv @@
// ----------------------------------------------------------------------------
// Melody follower core testbench
// Drives load, voiced, unvoiced and spare-opcode words into the core through
// bursty, stalling handshakes. A scoreboard with its own trellis predictor
// checks every result word in order.
// ----------------------------------------------------------------------------
module viterbi_melody_follower_core_tb import vmf_pkg::*; ;

   localparam int NOTES       = 64;
   localparam int BEAT_BLOCKS = 43;
   localparam int ITEM_TARGET = 140;
   localparam int IDLE_LIMIT  = 40000;
   localparam logic [1:0] OPC_SPARE = 2'd3;

   // One input word.
   typedef struct {
      logic [1:0]         op;
      logic [5:0]         idx;
      logic [PITCH_W-1:0] pitch;
      logic [LEN_W-1:0]   blocks;
      logic [POS_W-1:0]   pos;
      logic [MEAS_W-1:0]  meas;
   } note_word_type;

   // One result word.
   typedef struct {
      logic        hit;
      logic [16:0] pos1;
      logic [5:0]  winner;
   } follow_result_type;

   // The scoreboard keeps its own copy of the trellis state and predicts the
   // result of every accepted word. Results are checked in arrival order.
   class scoreboard_type;
      int signed   path[NOTES];
      int unsigned pitch_tab[NOTES];
      int unsigned len_tab[NOTES];
      int unsigned pos_tab[NOTES];
      int unsigned active;
      int unsigned run_len;
      follow_result_type expected_results[$];
      int mismatches;

      function new();
         foreach (path[k]) begin
            path[k] = 0;
            pitch_tab[k] = 0;
            len_tab[k] = 0;
            pos_tab[k] = 0;
         end
         path[0] = 177;
         active = 0;
         run_len = 0;
         mismatches = 0;
      endfunction

      function int signed clamp32(longint v);
         if (v > 64'sd2147483647) return 32'h7fffffff;
         if (v < -64'sd2147483648) return 32'h80000000;
         return int'(v);
      endfunction

      // Natural log of a Q16 probability, in Q8.
      function int signed log_q8(int unsigned x);
         int p;
         longint unsigned y;
         int signed lg;
         longint v;
         longint mag;
         p = 0;
         while (p < 31 && (x >> (p + 1)) != 0) p++;
         y = longint'(x) << (30 - p);
         lg = (p - 16) * 4096;
         for (int i = 0; i < 12; i++) begin
            y = (y * y) >> 30;
            if (y >= 64'h8000_0000) begin
               y = y >> 1;
               lg += 1 << (11 - i);
            end
         end
         v = longint'(lg) * 2839;
         mag = (v < 0) ? -v : v;
         mag = (mag + 32768) >>> 16;
         return (v < 0) ? -int'(mag) : int'(mag);
      endfunction

      function void note_input(note_word_type w);
         follow_result_type r;
         int signed ln_s[NOTES];
         int signed ln_n[NOTES];
         int signed ln_o[NOTES];
         int signed nxt[NOTES];
         int unsigned rem, c, win;
         int signed best, t, sc, e;
         longint obs;
         r = '{hit: 1'b0, pos1: '0, winner: '0};
         case (w.op)
            OPC_LOAD: begin
               pitch_tab[w.idx] = w.pitch;
               len_tab[w.idx] = w.blocks;
               pos_tab[w.idx] = w.pos;
               active = w.idx + 1;
               foreach (path[k]) path[k] = 0;
               path[0] = 177;
            end
            OPC_UNVOICED: run_len = 0;
            OPC_VOICED: begin
               if (run_len < 65535) run_len++;
               if (active != 0) begin
                  for (int o = 0; o < active; o++) begin
                     rem = (len_tab[o] > run_len) ? len_tab[o] - run_len : 0;
                     if (rem < BEAT_BLOCKS) c = 19661 - (16384 * rem) / BEAT_BLOCKS;
                     else c = 3277;
                     ln_s[o] = log_q8(65536 - c);
                     ln_n[o] = log_q8((c * 63984 + 32768) >> 16);
                     ln_o[o] = log_q8((c * 1553 + 32768) >> 16);
                  end
                  for (int s = 0; s < active; s++) begin
                     e = int'(pitch_tab[s]) * 16 - int'(w.meas);
                     obs = -(longint'(e) * longint'(e));
                     best = 0;
                     for (int o = 0; o < active; o++) begin
                        t = (o == s) ? ln_s[o] : (s == o + 1) ? ln_n[o] : ln_o[o];
                        sc = clamp32(longint'(clamp32(longint'(path[o]) + t)) + obs);
                        // Strictly greater keeps the lowest old state on a tie.
                        if (o == 0 || sc > best) best = sc;
                     end
                     nxt[s] = best;
                  end
                  win = 0;
                  for (int s = 1; s < active; s++) if (nxt[s] > nxt[win]) win = s;
                  for (int s = 0; s < active; s++)
                     path[s] = clamp32(longint'(nxt[s]) - longint'(nxt[win]));
                  r.hit = 1'b1;
                  r.pos1 = 17'(pos_tab[win] + 1);
                  r.winner = 6'(win);
               end
            end
            default: ;
         endcase
         expected_results.insert(expected_results.size(), r);
      endfunction

      function void check_result(follow_result_type got);
         follow_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: valid=%0d pos+1=%0d winner=%0d",
                        got.hit, got.pos1, got.winner);
            return;
         end
         want = expected_results.pop_front();
         if (got.hit !== want.hit || got.pos1 !== want.pos1 || got.winner !== want.winner) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: want valid=%0d pos+1=%0d win=%0d, got valid=%0d pos+1=%0d win=%0d",
                        want.hit, want.pos1, want.winner, got.hit, got.pos1, got.winner);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_opcode;
   logic [5:0]         req_entry_index;
   logic [PITCH_W-1:0] req_note_pitch;
   logic [LEN_W-1:0]   req_expected_blocks;
   logic [POS_W-1:0]   req_melody_position;
   logic [MEAS_W-1:0]  req_measured_pitch;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_result_valid;
   logic [16:0]        rsp_position_plus_one;
   logic [5:0]         rsp_winner_state;

   scoreboard_type   tracker;
   note_word_type    words[$];
   int               first_blank;   // lowest note slot that was never loaded
   int               results_seen;
   int               idle_cycles;
   bit               stimulus_done;

   viterbi_melody_follower_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_entry_index       (req_entry_index),
      .req_note_pitch        (req_note_pitch),
      .req_expected_blocks   (req_expected_blocks),
      .req_melody_position   (req_melody_position),
      .req_measured_pitch    (req_measured_pitch),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result_valid      (rsp_result_valid),
      .rsp_position_plus_one (rsp_position_plus_one),
      .rsp_winner_state      (rsp_winner_state)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Queues one word. A load may only target a slot at or below the lowest
   // slot never loaded, so a tick never reads an empty slot.
   task automatic add_word(logic [1:0] op, int idx, int pitch, int blocks, int pos, int meas);
      note_word_type w;
      if (op == OPC_LOAD && idx > first_blank) idx = first_blank;
      if (op == OPC_LOAD && idx == first_blank && first_blank < NOTES) first_blank++;
      w.op = op;
      w.idx = 6'(idx);
      w.pitch = 7'(pitch);
      w.blocks = 16'(blocks);
      w.pos = 16'(pos);
      w.meas = 11'(meas);
      words.insert(words.size(), w);
   endtask

   // Loads a melody of n notes into slots 0..n-1, then follows it with a run
   // of ticks whose measured pitch mostly lies near one of the loaded notes.
   task automatic add_melody(int n);
      int pitches[NOTES];
      int pos_base, ticks, pick, meas;
      pos_base = $urandom_range(0, 60000);
      for (int k = 0; k < n; k++) begin
         pitches[k] = $urandom_range(36, 96);
         add_word(OPC_LOAD, k, pitches[k],
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 120),
                  pos_base + k * $urandom_range(1, 3), 0);
      end
      ticks = $urandom_range(3, 12);
      for (int t = 0; t < ticks; t++) begin
         pick = $urandom_range(0, n - 1);
         meas = pitches[pick] * 16 + $urandom_range(0, 40) - 20;
         if ($urandom_range(0, 7) == 0) meas = $urandom_range(0, 2047);
         if ($urandom_range(0, 9) == 0)
            add_word(OPC_UNVOICED, $urandom_range(0, 63), $urandom_range(0, 127),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), meas);
         else
            add_word(OPC_VOICED, $urandom_range(0, 63), $urandom_range(0, 127),
                     $urandom_range(0, 65535), $urandom_range(0, 65535), meas);
      end
   endtask

   task automatic build_stimulus();
      int kind;
      // Directed part: a tick with no notes, the spare opcode, extreme fields,
      // a position whose plus one reaches 65536, ties between identical notes and the
      // last state that has no successor.
      add_word(OPC_VOICED, 0, 0, 0, 0, 0);
      add_word(OPC_SPARE, 63, 127, 65535, 65535, 2047);
      add_word(OPC_UNVOICED, 0, 0, 0, 0, 0);
      add_word(OPC_LOAD, 0, 127, 65535, 65535, 2047);
      add_word(OPC_VOICED, 0, 0, 0, 0, 2047);
      add_word(OPC_VOICED, 0, 0, 0, 0, 0);
      add_word(OPC_LOAD, 1, 0, 0, 0, 0);
      add_word(OPC_VOICED, 0, 0, 0, 0, 0);
      add_word(OPC_VOICED, 0, 0, 0, 0, 2047);
      add_word(OPC_LOAD, 0, 60, 0, 100, 0);
      add_word(OPC_LOAD, 1, 60, 0, 101, 0);
      add_word(OPC_LOAD, 2, 60, 43, 102, 0);
      add_word(OPC_VOICED, 0, 0, 0, 0, 960);
      add_word(OPC_VOICED, 0, 0, 0, 0, 960);
      add_word(OPC_UNVOICED, 0, 0, 0, 0, 0);
      add_word(OPC_VOICED, 0, 0, 0, 0, 961);
      add_word(OPC_LOAD, 0, 62, 42, 7, 0);
      add_word(OPC_VOICED, 63, 127, 65535, 65535, 992);
      // Random part: one melody at full size, then small melodies with raw
      // noise words in between.
      add_melody(NOTES);
      while (words.size() < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            add_melody($urandom_range(1, 6));
         end else begin
            add_word(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 127),
                     $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 2047));
         end
      end
   endtask

   // Sender: bursts of words with random gaps between them.
   initial begin
      int i, burst, gap;
      tracker = new();
      stimulus_done = 1'b0;
      first_blank = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OPC_LOAD;
      req_entry_index = '0;
      req_note_pitch = '0;
      req_expected_blocks = '0;
      req_melody_position = '0;
      req_measured_pitch = '0;
      build_stimulus();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      i = 0;
      while (i < words.size()) begin
         burst = $urandom_range(1, 8);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         for (int b = 0; b < burst && i < words.size(); b++) begin
            req_valid = 1'b1;
            req_opcode = words[i].op;
            req_entry_index = words[i].idx;
            req_note_pitch = words[i].pitch;
            req_expected_blocks = words[i].blocks;
            req_melody_position = words[i].pos;
            req_measured_pitch = words[i].meas;
            do @(posedge clock); while (!req_ready);
            tracker.note_input(words[i]);
            i++;
            @(negedge clock);
         end
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      stimulus_done = 1'b1;
   end

   // Receiver: the stall pattern switches to a random mode at random times. Once,
   // after 30 results, it holds off long enough for the core to fill and stall
   // the sender.
   initial begin
      int mode;
      bit held;
      rsp_ready = 1'b0;
      held = 1'b0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= 30) begin
            held = 1'b1;
            rsp_ready = 1'b0;
            repeat (3000) @(negedge clock);
         end
         if ($urandom_range(0, 49) == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_ready = 1'b1;
            1: rsp_ready = ($urandom_range(0, 3) == 0);
            2: rsp_ready = $urandom_range(0, 1);
            default: rsp_ready = ($urandom_range(0, 15) != 0);
         endcase
      end
   end

   initial results_seen = 0;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result('{hit: rsp_result_valid, pos1: rsp_position_plus_one,
                                winner: rsp_winner_state});
         results_seen++;
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   initial idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL viterbi_melody_follower_core");
            $finish;
         end
      end
   end

   // End of run: every expected result has arrived, then a short drain.
   initial begin
      wait (stimulus_done);
      while (tracker.expected_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_results.size() == 0) begin
         $display("PASS viterbi_melody_follower_core");
      end else begin
         $display("FAIL viterbi_melody_follower_core");
      end
      $finish;
   end

endmodule
